@@ rtl/core/twrs_pkg.sv @@
`default_nettype none

package twrs_pkg;

    localparam int DEF_WRITE_ENTRIES = 16;
    localparam int DEF_READ_ENTRIES  = 32;
    localparam int DEF_ADDR_BITS     = 32;

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_READ   = 3'd1,
        CMD_QUERY  = 3'd2,
        CMD_COMMIT = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    localparam logic [2:0] FLT_NONE     = 3'd0;
    localparam logic [2:0] FLT_WB_FULL  = 3'd1;
    localparam logic [2:0] FLT_RS_FULL  = 3'd2;
    localparam logic [2:0] FLT_BAD_SIZE = 3'd3;
    localparam logic [2:0] FLT_HI_MISS  = 3'd4;

    localparam logic [3:0] SIZE_1 = 4'd1;
    localparam logic [3:0] SIZE_2 = 4'd2;
    localparam logic [3:0] SIZE_4 = 4'd4;
    localparam logic [3:0] SIZE_8 = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic scan_step;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_commit;
        logic buf_empty;
        logic scan_end;
        logic last_word;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/core/transactional_write_read_set_top.sv @@
// Channel   Handshake          Fields
// -------   ----------------   ---------------------------------------------------
// command   start, busy        i_command, i_address, i_access_size, i_write_data,
//                              i_memory_word
// result    o_strobe           o_read_hit, o_read_value, o_conflict, o_commit_valid,
//                              o_commit_word_address, o_commit_word_data,
//                              o_buffered_count, o_fault, o_last_result
//
// A word is taken when start is high and busy is low. Write, read, query, clear
// and unknown commands give one result two cycles after acceptance; busy is high
// for one cycle. Commit with n buffered words scans the write buffer once per
// emitted word, one entry a cycle, so it takes n * (WRITE_ENTRIES + 1) + 1 cycles;
// the single-ported scan over the buffer sets that figure.
// Reset is synchronous, active low; it empties both tables at once.
// Results are shown for one cycle each and cannot be stalled.
`default_nettype none

module transactional_write_read_set_top #(
    parameter int WRITE_ENTRIES = twrs_pkg::DEF_WRITE_ENTRIES,
    parameter int READ_ENTRIES  = twrs_pkg::DEF_READ_ENTRIES,
    parameter int ADDR_BITS     = twrs_pkg::DEF_ADDR_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  i_command,
    input  wire  [31:0] i_address,
    input  wire  [3:0]  i_access_size,
    input  wire  [63:0] i_write_data,
    input  wire  [31:0] i_memory_word,
    output logic        o_strobe,
    output logic        o_read_hit,
    output logic [63:0] o_read_value,
    output logic        o_conflict,
    output logic        o_commit_valid,
    output logic [31:0] o_commit_word_address,
    output logic [31:0] o_commit_word_data,
    output logic [4:0]  o_buffered_count,
    output logic [2:0]  o_fault,
    output logic        o_last_result
);

    // commands down to the datapath, status back up
    twrs_pkg::t_dp_cmd    dp_cmd;
    twrs_pkg::t_dp_status dp_status;

    twrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // tables, lookups, commit scan and result registers
    twrs_datapath #(
        .WRITE_ENTRIES (WRITE_ENTRIES),
        .READ_ENTRIES  (READ_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (dp_cmd),
        .o_status              (dp_status),
        .i_command             (i_command),
        .i_address             (i_address),
        .i_access_size         (i_access_size),
        .i_write_data          (i_write_data),
        .i_memory_word         (i_memory_word),
        .o_strobe              (o_strobe),
        .o_read_hit            (o_read_hit),
        .o_read_value          (o_read_value),
        .o_conflict            (o_conflict),
        .o_commit_valid        (o_commit_valid),
        .o_commit_word_address (o_commit_word_address),
        .o_commit_word_data    (o_commit_word_data),
        .o_buffered_count      (o_buffered_count),
        .o_fault               (o_fault),
        .o_last_result         (o_last_result)
    );

endmodule

`default_nettype wire

@@ rtl/core/twrs_ctrl.sv @@
`default_nettype none

module twrs_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  twrs_pkg::t_dp_status  i_status,
    output twrs_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_commit && !i_status.buf_empty) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_end) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = i_status.last_word ? ST_IDLE : ST_SCAN;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

@@ rtl/core/twrs_datapath.sv @@
`default_nettype none

module twrs_datapath #(
    parameter int WRITE_ENTRIES = twrs_pkg::DEF_WRITE_ENTRIES,
    parameter int READ_ENTRIES  = twrs_pkg::DEF_READ_ENTRIES,
    parameter int ADDR_BITS     = twrs_pkg::DEF_ADDR_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  twrs_pkg::t_dp_cmd     i_cmd,
    output twrs_pkg::t_dp_status  o_status,
    input  wire  [2:0]            i_command,
    input  wire  [31:0]           i_address,
    input  wire  [3:0]            i_access_size,
    input  wire  [63:0]           i_write_data,
    input  wire  [31:0]           i_memory_word,
    output logic                  o_strobe,
    output logic                  o_read_hit,
    output logic [63:0]           o_read_value,
    output logic                  o_conflict,
    output logic                  o_commit_valid,
    output logic [31:0]           o_commit_word_address,
    output logic [31:0]           o_commit_word_data,
    output logic [4:0]            o_buffered_count,
    output logic [2:0]            o_fault,
    output logic                  o_last_result
);

    localparam int WA_W = ADDR_BITS - 2;
    localparam int WIDX = (WRITE_ENTRIES > 1) ? $clog2(WRITE_ENTRIES) : 1;
    localparam int RIDX = (READ_ENTRIES > 1) ? $clog2(READ_ENTRIES) : 1;
    localparam int WCNT = $clog2(WRITE_ENTRIES + 1);
    localparam int RCNT = $clog2(READ_ENTRIES + 1);

    // latched command word
    logic [2:0]  r_command;
    logic [31:0] r_address;
    logic [3:0]  r_size;
    logic [63:0] r_wdata;
    logic [31:0] r_mem;

    // write buffer and read set
    logic [WA_W-1:0]    r_buf_addr [WRITE_ENTRIES];
    logic [31:0]        r_buf_data [WRITE_ENTRIES];
    logic [WRITE_ENTRIES-1:0] r_buf_valid;
    logic [WCNT-1:0]    r_wb_count;
    logic [WA_W-1:0]    r_rs_addr [READ_ENTRIES];
    logic [READ_ENTRIES-1:0]  r_rs_valid;
    logic [RCNT-1:0]    r_rs_count;

    // commit scan
    logic [WIDX-1:0]    r_scan_idx;
    logic               r_best_v;
    logic [WIDX-1:0]    r_best_idx;
    logic [WA_W-1:0]    r_last_addr;
    logic               r_have_last;
    logic [WCNT-1:0]    r_emitted;

    // result registers
    logic        r_strobe;
    logic        r_read_hit;
    logic [63:0] r_read_value;
    logic        r_conflict;
    logic        r_commit_valid;
    logic [31:0] r_commit_addr;
    logic [31:0] r_commit_data;
    logic [4:0]  r_count_out;
    logic [2:0]  r_fault;
    logic        r_last;

    logic [1:0]      off;
    logic [WA_W-1:0] wa;
    logic [WA_W-1:0] hi;
    logic            shape_ok;
    logic [WRITE_ENTRIES-1:0] hit_lo_v;
    logic [WRITE_ENTRIES-1:0] hit_hi_v;
    logic            hit_lo;
    logic            hit_hi;
    logic [WIDX-1:0] idx_lo;
    logic [WIDX-1:0] idx_hi;
    logic [WIDX-1:0] wf1;
    logic [WIDX-1:0] wf2;
    logic [RIDX-1:0] rf1;
    logic [RIDX-1:0] rf2;
    logic            rs_wa;
    logic            rs_hi;
    logic [3:0]      be;
    logic [31:0]     bmask;
    logic [31:0]     dshift;
    logic [31:0]     lane;
    logic [31:0]     data_lo;
    logic [31:0]     data_hi;
    logic [1:0]      need_w;
    logic [1:0]      need_r;

    // update plan
    logic            wpa_en;
    logic [WIDX-1:0] wpa_idx;
    logic [WA_W-1:0] wpa_addr;
    logic [31:0]     wpa_data;
    logic            wpb_en;
    logic [WIDX-1:0] wpb_idx;
    logic [WA_W-1:0] wpb_addr;
    logic [31:0]     wpb_data;
    logic [1:0]      w_inc;
    logic            rpa_en;
    logic [RIDX-1:0] rpa_idx;
    logic [WA_W-1:0] rpa_addr;
    logic            rpb_en;
    logic [RIDX-1:0] rpb_idx;
    logic [WA_W-1:0] rpb_addr;
    logic [1:0]      r_inc_n;
    logic            clr;
    logic            n_read_hit;
    logic [63:0]     n_read_value;
    logic            n_conflict;
    logic [2:0]      n_fault;
    logic [WCNT-1:0] n_wb_count;
    logic            take_cand;
    logic [WA_W-1:0] scan_addr;

    function automatic logic [31:0] merge_word(input logic [31:0] old_w,
                                               input logic [31:0] mask,
                                               input logic [31:0] d);
        merge_word = (old_w & ~mask) | (d & mask);
    endfunction

    assign off = r_address[1:0];
    assign wa  = WA_W'(r_address >> 2);
    assign hi  = wa + WA_W'(1);

    always_comb begin
        unique case (r_size)
            twrs_pkg::SIZE_1: shape_ok = 1'b1;
            twrs_pkg::SIZE_2: shape_ok = (off != 2'd3);
            twrs_pkg::SIZE_4,
            twrs_pkg::SIZE_8: shape_ok = (off == 2'd0);
            default:          shape_ok = 1'b0;
        endcase
    end

    // associative lookup and free-slot search
    always_comb begin
        idx_lo = '0;
        idx_hi = '0;
        for (int i = 0; i < WRITE_ENTRIES; i++) begin
            hit_lo_v[i] = r_buf_valid[i] && (r_buf_addr[i] == wa);
            hit_hi_v[i] = r_buf_valid[i] && (r_buf_addr[i] == hi);
            if (hit_lo_v[i]) idx_lo = WIDX'(i);
            if (hit_hi_v[i]) idx_hi = WIDX'(i);
        end
        hit_lo = |hit_lo_v;
        hit_hi = |hit_hi_v;
        wf1 = '0;
        for (int i = WRITE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_buf_valid[i]) wf1 = WIDX'(i);
        end
        wf2 = '0;
        for (int i = WRITE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_buf_valid[i] && (WIDX'(i) != wf1)) wf2 = WIDX'(i);
        end
    end

    always_comb begin
        rs_wa = 1'b0;
        rs_hi = 1'b0;
        for (int i = 0; i < READ_ENTRIES; i++) begin
            if (r_rs_valid[i] && (r_rs_addr[i] == wa)) rs_wa = 1'b1;
            if (r_rs_valid[i] && (r_rs_addr[i] == hi)) rs_hi = 1'b1;
        end
        rf1 = '0;
        for (int i = READ_ENTRIES - 1; i >= 0; i--) begin
            if (!r_rs_valid[i]) rf1 = RIDX'(i);
        end
        rf2 = '0;
        for (int i = READ_ENTRIES - 1; i >= 0; i--) begin
            if (!r_rs_valid[i] && (RIDX'(i) != rf1)) rf2 = RIDX'(i);
        end
    end

    assign data_lo = r_buf_data[idx_lo];
    assign data_hi = r_buf_data[idx_hi];

    always_comb begin
        unique case (r_size)
            twrs_pkg::SIZE_1: begin be = 4'b0001 << off; lane = 32'h0000_00FF; end
            twrs_pkg::SIZE_2: begin be = 4'b0011 << off; lane = 32'h0000_FFFF; end
            default:          begin be = 4'b1111;        lane = 32'hFFFF_FFFF; end
        endcase
    end

    assign bmask  = {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
    assign dshift = r_wdata[31:0] << {off, 3'b000};
    assign need_w = {1'b0, !hit_lo} + {1'b0, !hit_hi};
    assign need_r = {1'b0, !rs_wa} + {1'b0, (r_size == twrs_pkg::SIZE_8) && !rs_hi};

    always_comb begin
        wpa_en = 1'b0; wpa_idx = wf1; wpa_addr = wa; wpa_data = '0;
        wpb_en = 1'b0; wpb_idx = wf2; wpb_addr = wa; wpb_data = '0;
        rpa_en = 1'b0; rpa_idx = rf1; rpa_addr = wa;
        rpb_en = 1'b0; rpb_idx = rf2; rpb_addr = hi;
        w_inc = '0;
        r_inc_n = '0;
        clr = 1'b0;
        n_read_hit = 1'b0;
        n_read_value = '0;
        n_conflict = 1'b0;
        n_fault = twrs_pkg::FLT_NONE;
        case (r_command)
            twrs_pkg::CMD_WRITE: begin
                if (!shape_ok) begin
                    n_fault = twrs_pkg::FLT_BAD_SIZE;
                end else if (r_size == twrs_pkg::SIZE_8) begin
                    if ((WCNT+1)'(r_wb_count) + (WCNT+1)'(need_w)
                            > (WCNT+1)'(WRITE_ENTRIES)) begin
                        n_fault = twrs_pkg::FLT_WB_FULL;
                    end else begin
                        wpa_en   = 1'b1;
                        wpa_idx  = hit_hi ? idx_hi : wf1;
                        wpa_addr = hi;
                        wpa_data = r_wdata[63:32];
                        wpb_en   = 1'b1;
                        wpb_idx  = hit_lo ? idx_lo : (hit_hi ? wf1 : wf2);
                        wpb_addr = wa;
                        wpb_data = r_wdata[31:0];
                        w_inc    = need_w;
                    end
                end else if (hit_lo) begin
                    wpa_en   = 1'b1;
                    wpa_idx  = idx_lo;
                    wpa_data = merge_word(data_lo, bmask, dshift);
                end else if (r_wb_count == WCNT'(WRITE_ENTRIES)) begin
                    n_fault = twrs_pkg::FLT_WB_FULL;
                end else if ((r_size != twrs_pkg::SIZE_4) && !rs_wa
                             && (r_rs_count == RCNT'(READ_ENTRIES))) begin
                    n_fault = twrs_pkg::FLT_RS_FULL;
                end else begin
                    // a partial first store reads the rest of the word
                    if ((r_size != twrs_pkg::SIZE_4) && !rs_wa) begin
                        rpa_en  = 1'b1;
                        r_inc_n = 2'd1;
                    end
                    wpa_en   = 1'b1;
                    wpa_data = merge_word(r_mem, bmask, dshift);
                    w_inc    = 2'd1;
                end
            end
            twrs_pkg::CMD_READ: begin
                if (!shape_ok) begin
                    n_fault = twrs_pkg::FLT_BAD_SIZE;
                end else if ((RCNT+1)'(r_rs_count) + (RCNT+1)'(need_r)
                             > (RCNT+1)'(READ_ENTRIES)) begin
                    n_fault = twrs_pkg::FLT_RS_FULL;
                end else begin
                    rpa_en  = !rs_wa;
                    rpb_en  = (r_size == twrs_pkg::SIZE_8) && !rs_hi;
                    rpb_idx = rs_wa ? rf1 : rf2;
                    r_inc_n = need_r;
                    if (hit_lo) begin
                        if (r_size == twrs_pkg::SIZE_8) begin
                            if (hit_hi) begin
                                n_read_hit   = 1'b1;
                                n_read_value = {data_hi, data_lo};
                            end else begin
                                n_fault = twrs_pkg::FLT_HI_MISS;
                            end
                        end else begin
                            n_read_hit   = 1'b1;
                            n_read_value = 64'((data_lo >> {off, 3'b000}) & lane);
                        end
                    end
                end
            end
            twrs_pkg::CMD_QUERY: begin
                n_conflict = rs_wa || ((r_size > twrs_pkg::SIZE_4) && rs_hi);
            end
            twrs_pkg::CMD_CLEAR: begin
                clr = 1'b1;
            end
            default: ;
        endcase
    end

    assign n_wb_count = clr ? '0 : (r_wb_count + WCNT'(w_inc));
    assign scan_addr  = r_buf_addr[r_scan_idx];
    assign take_cand  = r_buf_valid[r_scan_idx]
                        && (!r_have_last || (scan_addr > r_last_addr))
                        && (!r_best_v || (scan_addr < r_buf_addr[r_best_idx]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_command <= i_command;
            r_address <= i_address;
            r_size    <= i_access_size;
            r_wdata   <= i_write_data;
            r_mem     <= i_memory_word;
        end
        if (i_cmd.exec) begin
            if (wpa_en) begin
                r_buf_addr[wpa_idx] <= wpa_addr;
                r_buf_data[wpa_idx] <= wpa_data;
            end
            if (wpb_en) begin
                r_buf_addr[wpb_idx] <= wpb_addr;
                r_buf_data[wpb_idx] <= wpb_data;
            end
            if (rpa_en) r_rs_addr[rpa_idx] <= rpa_addr;
            if (rpb_en) r_rs_addr[rpb_idx] <= rpb_addr;
        end
        if (i_cmd.scan_step && take_cand) begin
            r_best_idx <= r_scan_idx;
        end
        if (i_cmd.emit) begin
            r_last_addr <= r_buf_addr[r_best_idx];
        end
        // result payload
        if (i_cmd.exec) begin
            r_read_hit     <= n_read_hit;
            r_read_value   <= n_read_value;
            r_conflict     <= n_conflict;
            r_commit_valid <= 1'b0;
            r_commit_addr  <= '0;
            r_commit_data  <= '0;
            r_count_out    <= 5'(n_wb_count);
            r_fault        <= n_fault;
            r_last         <= 1'b1;
        end else if (i_cmd.emit) begin
            r_read_hit     <= 1'b0;
            r_read_value   <= '0;
            r_conflict     <= 1'b0;
            r_commit_valid <= 1'b1;
            r_commit_addr  <= 32'({r_buf_addr[r_best_idx], 2'b00});
            r_commit_data  <= r_buf_data[r_best_idx];
            r_count_out    <= 5'(r_wb_count);
            r_fault        <= twrs_pkg::FLT_NONE;
            r_last         <= o_status.last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= '0;
            r_rs_valid  <= '0;
            r_wb_count  <= '0;
            r_rs_count  <= '0;
            r_scan_idx  <= '0;
            r_best_v    <= 1'b0;
            r_have_last <= 1'b0;
            r_emitted   <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.exec && !(o_status.is_commit && !o_status.buf_empty))
                        || i_cmd.emit;
            if (i_cmd.exec) begin
                if (clr) begin
                    r_buf_valid <= '0;
                    r_rs_valid  <= '0;
                    r_rs_count  <= '0;
                end else begin
                    if (wpa_en) r_buf_valid[wpa_idx] <= 1'b1;
                    if (wpb_en) r_buf_valid[wpb_idx] <= 1'b1;
                    if (rpa_en) r_rs_valid[rpa_idx] <= 1'b1;
                    if (rpb_en) r_rs_valid[rpb_idx] <= 1'b1;
                    r_rs_count <= r_rs_count + RCNT'(r_inc_n);
                end
                r_wb_count  <= n_wb_count;
                // arm the commit scan; a commit changes no table
                r_scan_idx  <= '0;
                r_best_v    <= 1'b0;
                r_have_last <= 1'b0;
                r_emitted   <= '0;
            end
            if (i_cmd.scan_step) begin
                r_scan_idx <= o_status.scan_end ? '0 : (r_scan_idx + WIDX'(1));
                if (take_cand) r_best_v <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_best_v    <= 1'b0;
                r_have_last <= 1'b1;
                r_emitted   <= r_emitted + WCNT'(1);
            end
        end
    end

    assign o_status.is_commit = (r_command == twrs_pkg::CMD_COMMIT);
    assign o_status.buf_empty = (r_wb_count == '0);
    assign o_status.scan_end  = (r_scan_idx == WIDX'(WRITE_ENTRIES - 1));
    assign o_status.last_word = ((WCNT+1)'(r_emitted) + (WCNT+1)'(1))
                                == (WCNT+1)'(r_wb_count);

    assign o_strobe              = r_strobe;
    assign o_read_hit            = r_read_hit;
    assign o_read_value          = r_read_value;
    assign o_conflict            = r_conflict;
    assign o_commit_valid        = r_commit_valid;
    assign o_commit_word_address = r_commit_addr;
    assign o_commit_word_data    = r_commit_data;
    assign o_buffered_count      = r_count_out;
    assign o_fault               = r_fault;
    assign o_last_result         = r_last;

endmodule

`default_nettype wire

@@ rtl/core/twrs_checker.sv @@
`default_nettype none

module twrs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_strobe,
    input wire        o_read_hit,
    input wire [63:0] o_read_value,
    input wire        o_commit_valid,
    input wire [2:0]  o_fault,
    input wire        o_last_result
);

    // an accepted word always holds busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without pending word");

    // more commit words to come keep the block busy
    a_mid_commit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_result) |-> (busy && o_commit_valid))
        else $error("non-final result outside commit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_read_hit) |-> (o_read_value == 64'd0))
        else $error("read value set without hit");

    a_commit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_commit_valid) |-> (o_fault == twrs_pkg::FLT_NONE))
        else $error("fault on commit word");

endmodule

bind transactional_write_read_set_top twrs_checker u_twrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_read_hit     (o_read_hit),
    .o_read_value   (o_read_value),
    .o_commit_valid (o_commit_valid),
    .o_fault        (o_fault),
    .o_last_result  (o_last_result)
);

`default_nettype wire
